// ===== rtl/core/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// Cleaning cycle sequencer package
// Shared phase encoding, drive codes, register indexes and item structs.
// ----------------------------------------------------------------------------
package ccs_pkg;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_HOME_DRUM = 4'd1,
      PH_HOME_GATE = 4'd2,
      PH_SETTLE    = 4'd3,
      PH_OPEN_GATE = 4'd4,
      PH_DRUM_OUT  = 4'd5,
      PH_SPRAY     = 4'd6,
      PH_RET_DRUM  = 4'd7,
      PH_RET_GATE  = 4'd8
   } phase_type;

   // motor drive codes
   localparam logic [1:0] DRV_STOP = 2'd0;
   localparam logic [1:0] DRV_BACK = 2'd1;
   localparam logic [1:0] DRV_FWD  = 2'd2;

   // configuration register indexes
   localparam logic [7:0] CSR_SETTLE_WAIT = 8'd0;
   localparam logic [7:0] CSR_SPRAY_WAIT  = 8'd1;

   localparam logic [7:0] WAIT_RESET = 8'd4;
   localparam logic [7:0] SEC_MAX    = 8'hFF;

   typedef struct packed {
      logic second_pulse;
      logic gate_open_switch;
      logic gate_closed_switch;
      logic drum_front_switch;
      logic drum_back_switch;
      logic start_request;
   } tick_type;

   typedef struct packed {
      logic [15:0] cleanings_count;
      logic        cycle_done;
      logic        busy_res;
      logic        spray_on;
      logic [1:0]  gate_drive;
      logic [1:0]  drum_drive;
   } result_type;

endpackage

// ===== rtl/core/ccs_step.sv =====
// ----------------------------------------------------------------------------
// Cleaning cycle sequencer step
// Phase register, seconds counter and cycle counter; computes one result per
// tick and advances the state when the tick is taken.
// ----------------------------------------------------------------------------
module ccs_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  ccs_pkg::tick_type   tick,
   input  logic [7:0]          settle_wait,
   input  logic [7:0]          spray_wait,
   output ccs_pkg::result_type result
);

   ccs_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         secs_ff, secs_in;
   logic [15:0]        count_ff, count_in;

   logic       drum_home, drum_end, gate_shut, gate_wide;
   logic [7:0] secs_cnt;
   logic       settle_end, spray_end;

   // both switches of an axis active means not in position
   assign drum_home = tick.drum_back_switch   & ~tick.drum_front_switch;
   assign drum_end  = tick.drum_front_switch  & ~tick.drum_back_switch;
   assign gate_shut = tick.gate_closed_switch & ~tick.gate_open_switch;
   assign gate_wide = tick.gate_open_switch   & ~tick.gate_closed_switch;

   assign secs_cnt   = (tick.second_pulse && secs_ff != ccs_pkg::SEC_MAX) ?
                       secs_ff + 8'd1 : secs_ff;
   assign settle_end = secs_cnt >= settle_wait;
   assign spray_end  = secs_cnt >= spray_wait;

   // next state
   always_comb begin
      phase_in = phase_ff;
      secs_in  = secs_ff;
      count_in = count_ff;
      case (phase_ff)
         ccs_pkg::PH_HOME_DRUM: begin
            if (drum_home) phase_in = ccs_pkg::PH_HOME_GATE;
         end
         ccs_pkg::PH_HOME_GATE: begin
            if (gate_shut) begin
               phase_in = ccs_pkg::PH_SETTLE;
               secs_in  = '0;
            end
         end
         ccs_pkg::PH_SETTLE: begin
            secs_in = secs_cnt;
            if (settle_end) phase_in = ccs_pkg::PH_OPEN_GATE;
         end
         ccs_pkg::PH_OPEN_GATE: begin
            if (gate_wide) phase_in = ccs_pkg::PH_DRUM_OUT;
         end
         ccs_pkg::PH_DRUM_OUT: begin
            if (drum_end) begin
               phase_in = ccs_pkg::PH_SPRAY;
               secs_in  = '0;
            end
         end
         ccs_pkg::PH_SPRAY: begin
            secs_in = secs_cnt;
            if (spray_end) phase_in = ccs_pkg::PH_RET_DRUM;
         end
         ccs_pkg::PH_RET_DRUM: begin
            if (drum_home) phase_in = ccs_pkg::PH_RET_GATE;
         end
         ccs_pkg::PH_RET_GATE: begin
            if (gate_shut) begin
               phase_in = ccs_pkg::PH_IDLE;
               count_in = count_ff + 16'd1;
            end
         end
         default: begin
            phase_in = tick.start_request ? ccs_pkg::PH_HOME_DRUM : ccs_pkg::PH_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      result            = '0;
      result.busy_res   = 1'b1;
      result.cleanings_count = count_in;
      case (phase_ff)
         ccs_pkg::PH_HOME_DRUM: begin
            if (!drum_home) result.drum_drive = ccs_pkg::DRV_BACK;
         end
         ccs_pkg::PH_HOME_GATE: begin
            if (!gate_shut) result.gate_drive = ccs_pkg::DRV_BACK;
         end
         ccs_pkg::PH_SETTLE: begin
            result.drum_drive = ccs_pkg::DRV_STOP;
         end
         ccs_pkg::PH_OPEN_GATE: begin
            if (!gate_wide) result.gate_drive = ccs_pkg::DRV_FWD;
         end
         ccs_pkg::PH_DRUM_OUT: begin
            if (!drum_end) result.drum_drive = ccs_pkg::DRV_FWD;
         end
         ccs_pkg::PH_SPRAY: begin
            result.spray_on = ~spray_end;
         end
         ccs_pkg::PH_RET_DRUM: begin
            if (!drum_home) result.drum_drive = ccs_pkg::DRV_BACK;
         end
         ccs_pkg::PH_RET_GATE: begin
            if (gate_shut) result.cycle_done = 1'b1;
            else           result.gate_drive = ccs_pkg::DRV_BACK;
         end
         default: begin
            result.busy_res = tick.start_request;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ccs_pkg::PH_IDLE;
         secs_ff  <= '0;
         count_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         secs_ff  <= secs_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/core/cleaning_cycle_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Cleaning cycle sequencer top level
// Stream wrapper: input register, sequencer step, result register, CSRs.
// ----------------------------------------------------------------------------
// One transfer on req_ is one clock tick of the machine (switch levels, the
// one-second pulse and the start request); each produces exactly one transfer
// on rsp_ with the motor drives, spray, busy, done and the cycle count. The
// block takes one tick per clock while rsp_tready is high: a tick sits in the
// input register, the sequencer step turns it into a result in the same cycle
// and the result register holds it for the consumer. Wait times are set
// through csr_ (index 0 settle seconds, index 1 spray seconds, both reset to
// 4); write them only while no tick is in flight.
module cleaning_cycle_sequencer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] start_request [1] drum_back_switch [2] drum_front_switch
   // [3] gate_closed_switch [4] gate_open_switch [5] second_pulse [7:6] zero
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] drum_drive [3:2] gate_drive [4] spray_on [5] busy_res
   // [6] cycle_done [22:7] cleanings_count [23] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   logic                s1_valid_ff, s1_valid_in;
   ccs_pkg::tick_type   s1_tick_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   ccs_pkg::result_type rsp_data_ff, step_result;
   logic [7:0]          settle_ff, spray_ff;
   logic                out_free, advance, req_xfer;

   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign advance     = s1_valid_ff & out_free;
   assign req_tready  = ~s1_valid_ff | out_free;
   assign req_xfer    = req_tvalid & req_tready;

   assign s1_valid_in  = req_xfer | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance  | (rsp_valid_ff & ~rsp_tready);

   ccs_step u_step (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .tick        (s1_tick_ff),
      .settle_wait (settle_ff),
      .spray_wait  (spray_ff),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) s1_tick_ff <= ccs_pkg::tick_type'(req_tdata[5:0]);
      if (advance)  rsp_data_ff <= step_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= ccs_pkg::WAIT_RESET;
         spray_ff  <= ccs_pkg::WAIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            ccs_pkg::CSR_SETTLE_WAIT: settle_ff <= csr_wdata;
            ccs_pkg::CSR_SPRAY_WAIT:  spray_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

// ===== rtl/core/ccs_checker.sv =====
// ----------------------------------------------------------------------------
// Cleaning cycle sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ccs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // drive fields carry only defined codes
   a_drive_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3 && rsp_tdata[3:2] != 2'd3)
      else $error("undefined motor drive code");

   // completion tick is busy, motors stopped, no spray
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |->
         rsp_tdata[5] && !rsp_tdata[4] &&
         rsp_tdata[1:0] == ccs_pkg::DRV_STOP && rsp_tdata[3:2] == ccs_pkg::DRV_STOP)
      else $error("cycle done with activity");

   // spray only with both motors stopped inside a cycle
   a_spray_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |->
         rsp_tdata[5] && rsp_tdata[1:0] == ccs_pkg::DRV_STOP &&
         rsp_tdata[3:2] == ccs_pkg::DRV_STOP)
      else $error("spray while a motor runs");

   // nothing presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind cleaning_cycle_sequencer_top ccs_checker u_ccs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/sv/cleaning_cycle_sequencer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cleaning cycle sequencer testbench
// Feeds machine ticks over the req_ stream and checks every rsp_ transfer
// field by field against an in-bench sequencer model. A directed walk through
// one full cycle comes first. Random segments at several wait settings follow,
// with random gaps and stalls and one long consumer hold-off. A short gapless
// burst with zero waits closes the run.
// ----------------------------------------------------------------------------
module cleaning_cycle_sequencer_top_tb;

   localparam int          CYCLE_LIMIT   = 3_000_000;
   localparam int          DIRECTED_ROWS = 25;
   localparam logic [7:0]  CSR_UNUSED_LO = 8'd2;
   localparam logic [7:0]  CSR_UNUSED_HI = 8'hFF;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_wr_en;
   logic [7:0]  csr_addr;
   logic [7:0]  csr_wdata;

   // sequencer model state
   ccs_pkg::phase_type seq_phase;
   logic [7:0]         seq_seconds;
   logic [15:0]        seq_count;
   logic [7:0]         settle_secs;
   logic [7:0]         spray_secs;

   ccs_pkg::result_type pending_results[$];
   int                  ticks_sent;
   int                  results_seen;
   int                  cycles_finished;
   int                  mismatches;
   int                  cycle_count;
   bit                  burst_on;

   cleaning_cycle_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic ccs_pkg::tick_type mk_tick(int s, int b, int f, int c, int o, int p);
      ccs_pkg::tick_type t;
      t.start_request      = 1'(s);
      t.drum_back_switch   = 1'(b);
      t.drum_front_switch  = 1'(f);
      t.gate_closed_switch = 1'(c);
      t.gate_open_switch   = 1'(o);
      t.second_pulse       = 1'(p);
      return t;
   endfunction

   function automatic ccs_pkg::result_type mk_result(logic [1:0] drum, logic [1:0] gate,
                                                     int spray, int busy, int done,
                                                     logic [15:0] count);
      ccs_pkg::result_type r;
      r.drum_drive      = drum;
      r.gate_drive      = gate;
      r.spray_on        = 1'(spray);
      r.busy_res        = 1'(busy);
      r.cycle_done      = 1'(done);
      r.cleanings_count = count;
      return r;
   endfunction

   // counts a pulse into the running wait; 1 once the wait has run out
   function automatic bit second_elapsed(logic pulse, logic [7:0] limit);
      if (pulse && seq_seconds != ccs_pkg::SEC_MAX)
         seq_seconds = seq_seconds + 8'd1;
      return seq_seconds >= limit;
   endfunction

   function automatic ccs_pkg::result_type advance_sequencer(ccs_pkg::tick_type t);
      ccs_pkg::result_type r;
      logic drum_home, drum_end, gate_shut, gate_wide;
      drum_home = t.drum_back_switch && !t.drum_front_switch;
      drum_end  = t.drum_front_switch && !t.drum_back_switch;
      gate_shut = t.gate_closed_switch && !t.gate_open_switch;
      gate_wide = t.gate_open_switch && !t.gate_closed_switch;
      r = '0;
      r.busy_res = 1'b1;
      case (seq_phase)
         ccs_pkg::PH_HOME_DRUM: begin
            if (drum_home) seq_phase = ccs_pkg::PH_HOME_GATE;
            else r.drum_drive = ccs_pkg::DRV_BACK;
         end
         ccs_pkg::PH_HOME_GATE: begin
            if (gate_shut) begin
               seq_phase   = ccs_pkg::PH_SETTLE;
               seq_seconds = 8'd0;
            end else begin
               r.gate_drive = ccs_pkg::DRV_BACK;
            end
         end
         ccs_pkg::PH_SETTLE: begin
            if (second_elapsed(t.second_pulse, settle_secs))
               seq_phase = ccs_pkg::PH_OPEN_GATE;
         end
         ccs_pkg::PH_OPEN_GATE: begin
            if (gate_wide) seq_phase = ccs_pkg::PH_DRUM_OUT;
            else r.gate_drive = ccs_pkg::DRV_FWD;
         end
         ccs_pkg::PH_DRUM_OUT: begin
            if (drum_end) begin
               seq_phase   = ccs_pkg::PH_SPRAY;
               seq_seconds = 8'd0;
            end else begin
               r.drum_drive = ccs_pkg::DRV_FWD;
            end
         end
         ccs_pkg::PH_SPRAY: begin
            if (second_elapsed(t.second_pulse, spray_secs))
               seq_phase = ccs_pkg::PH_RET_DRUM;
            else
               r.spray_on = 1'b1;
         end
         ccs_pkg::PH_RET_DRUM: begin
            if (drum_home) seq_phase = ccs_pkg::PH_RET_GATE;
            else r.drum_drive = ccs_pkg::DRV_BACK;
         end
         ccs_pkg::PH_RET_GATE: begin
            if (gate_shut) begin
               seq_phase    = ccs_pkg::PH_IDLE;
               r.cycle_done = 1'b1;
               seq_count    = seq_count + 16'd1;
               cycles_finished++;
            end else begin
               r.gate_drive = ccs_pkg::DRV_BACK;
            end
         end
         default: begin
            if (t.start_request) begin
               seq_phase = ccs_pkg::PH_HOME_DRUM;
            end else begin
               seq_phase  = ccs_pkg::PH_IDLE;
               r.busy_res = 1'b0;
            end
         end
      endcase
      r.cleanings_count = seq_count;
      return r;
   endfunction

   // force the switches / pulse that let the current phase move on
   function automatic ccs_pkg::tick_type steer_tick(ccs_pkg::tick_type t);
      case (seq_phase)
         ccs_pkg::PH_HOME_DRUM, ccs_pkg::PH_RET_DRUM: begin
            t.drum_back_switch  = 1'b1;
            t.drum_front_switch = 1'b0;
         end
         ccs_pkg::PH_HOME_GATE, ccs_pkg::PH_RET_GATE: begin
            t.gate_closed_switch = 1'b1;
            t.gate_open_switch   = 1'b0;
         end
         ccs_pkg::PH_OPEN_GATE: begin
            t.gate_open_switch   = 1'b1;
            t.gate_closed_switch = 1'b0;
         end
         ccs_pkg::PH_DRUM_OUT: begin
            t.drum_front_switch = 1'b1;
            t.drum_back_switch  = 1'b0;
         end
         ccs_pkg::PH_SETTLE, ccs_pkg::PH_SPRAY: t.second_pulse = 1'b1;
         default: t.start_request = 1'b1;
      endcase
      return t;
   endfunction

   // one full cycle at the reset waits (4 s / 4 s); columns: s b f c o p
   task automatic directed_row(input int i, output ccs_pkg::tick_type t, output bit typed,
                               output ccs_pkg::result_type r);
      typed = 1'b0;
      r     = '0;
      case (i)
         0:  begin
            t     = mk_tick(0, 1, 0, 1, 0, 1);
            typed = 1'b1;
            r     = mk_result(ccs_pkg::DRV_STOP, ccs_pkg::DRV_STOP, 0, 0, 0, 16'd0);
         end
         1:  begin
            t     = mk_tick(1, 1, 1, 1, 1, 1);
            typed = 1'b1;
            r     = mk_result(ccs_pkg::DRV_STOP, ccs_pkg::DRV_STOP, 0, 1, 0, 16'd0);
         end
         2:  t = mk_tick(0, 1, 1, 0, 0, 0);   // both drum switches: keep driving
         3:  t = mk_tick(1, 1, 0, 0, 1, 0);   // start while busy is ignored
         4:  t = mk_tick(0, 0, 0, 1, 1, 1);
         5:  t = mk_tick(0, 1, 0, 1, 0, 0);
         6:  t = mk_tick(1, 0, 1, 0, 1, 0);
         7:  t = mk_tick(0, 0, 0, 0, 0, 1);
         8:  t = mk_tick(0, 1, 1, 1, 1, 1);
         9:  t = mk_tick(0, 0, 1, 1, 0, 1);
         10: t = mk_tick(0, 1, 0, 0, 1, 1);
         11: t = mk_tick(0, 0, 0, 1, 1, 0);   // both gate switches while opening
         12: t = mk_tick(0, 0, 0, 0, 1, 0);
         13: t = mk_tick(0, 0, 0, 1, 0, 1);
         14: t = mk_tick(0, 0, 1, 0, 0, 0);
         15: t = mk_tick(0, 0, 1, 0, 0, 1);
         16: t = mk_tick(1, 1, 1, 1, 1, 1);
         17: t = mk_tick(0, 0, 0, 0, 0, 0);
         18: t = mk_tick(0, 0, 1, 0, 1, 1);
         19: t = mk_tick(0, 1, 0, 1, 0, 1);
         20: t = mk_tick(0, 1, 1, 0, 0, 0);
         21: t = mk_tick(0, 1, 0, 0, 0, 1);
         22: t = mk_tick(0, 0, 0, 0, 0, 0);
         23: begin
            t     = mk_tick(0, 0, 1, 1, 0, 0);
            typed = 1'b1;
            r     = mk_result(ccs_pkg::DRV_STOP, ccs_pkg::DRV_STOP, 0, 1, 1, 16'd1);
         end
         default: begin
            t     = mk_tick(0, 1, 1, 1, 1, 1);
            typed = 1'b1;
            r     = mk_result(ccs_pkg::DRV_STOP, ccs_pkg::DRV_STOP, 0, 0, 0, 16'd1);
         end
      endcase
   endtask

   task automatic feed_tick(input ccs_pkg::tick_type t, input bit typed,
                            input ccs_pkg::result_type typed_res);
      int                  gap;
      ccs_pkg::result_type r;
      if (burst_on) gap = 0;
      else if ((ticks_sent / 150) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = advance_sequencer(t);
      pending_results.push_back(typed ? typed_res : r);
      ticks_sent++;
   endtask

   task automatic run_random(input int count);
      ccs_pkg::tick_type t;
      repeat (count) begin
         t = ccs_pkg::tick_type'(6'($urandom_range(0, 63)));
         if ($urandom_range(0, 99) < 65) t = steer_tick(t);
         feed_tick(t, 1'b0, '0);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] addr, input logic [7:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      if (addr == ccs_pkg::CSR_SETTLE_WAIT) settle_secs = data;
      else if (addr == ccs_pkg::CSR_SPRAY_WAIT) spray_secs = data;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      ccs_pkg::result_type want;
      ccs_pkg::result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got = rsp_tdata[22:0];
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result transfer with nothing expected, actual %h", $time, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            check_field("drum_drive", 32'(want.drum_drive), 32'(got.drum_drive));
            check_field("gate_drive", 32'(want.gate_drive), 32'(got.gate_drive));
            check_field("spray_on", 32'(want.spray_on), 32'(got.spray_on));
            check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
            check_field("cycle_done", 32'(want.cycle_done), 32'(got.cycle_done));
            check_field("cleanings_count", 32'(want.cleanings_count),
                        32'(got.cleanings_count));
            check_field("tdata pad", 0, 32'(rsp_tdata[23]));
         end
      end
   end

   // consumer: random stalls, stall-free stretches, one long hold-off
   initial begin : rsp_sink
      int stall;
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && results_seen >= 150) begin
            held  = 1'b1;
            stall = 300;
         end else if (burst_on || (results_seen / 200) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      ccs_pkg::tick_type   t;
      bit                  typed;
      ccs_pkg::result_type r;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wr_en  <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      seq_phase   = ccs_pkg::PH_IDLE;
      seq_seconds = 8'd0;
      seq_count   = 16'd0;
      settle_secs = ccs_pkg::WAIT_RESET;
      spray_secs  = ccs_pkg::WAIT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         directed_row(i, t, typed, r);
         feed_tick(t, typed, r);
      end
      wait_idle();

      // unused indexes must not disturb either wait
      write_csr(CSR_UNUSED_LO, 8'h55);
      write_csr(CSR_UNUSED_HI, 8'hAA);
      write_csr(ccs_pkg::CSR_SETTLE_WAIT, 8'd1);
      write_csr(ccs_pkg::CSR_SPRAY_WAIT, 8'd2);
      run_random(650);
      wait_idle();

      write_csr(ccs_pkg::CSR_SETTLE_WAIT, ccs_pkg::SEC_MAX);
      write_csr(ccs_pkg::CSR_SPRAY_WAIT, ccs_pkg::SEC_MAX);
      run_random(650);
      wait_idle();

      // likely lands mid-wait: shorter limits cut the running wait short
      write_csr(ccs_pkg::CSR_SETTLE_WAIT, 8'd3);
      write_csr(ccs_pkg::CSR_SPRAY_WAIT, 8'd1);
      run_random(500);
      wait_idle();

      // zero waits and no idling: every tick moves the sequencer on, back to back
      write_csr(ccs_pkg::CSR_SETTLE_WAIT, 8'd0);
      write_csr(ccs_pkg::CSR_SPRAY_WAIT, 8'd0);
      burst_on = 1'b1;
      repeat (60)
         feed_tick(steer_tick(ccs_pkg::tick_type'(6'($urandom_range(0, 63)))), 1'b0, '0);
      burst_on = 1'b0;
      wait_idle();
      repeat (10) @(posedge clock);

      $display("run: %0d ticks, %0d cleaning cycles done", ticks_sent, cycles_finished);
      $display("run: waits of 0 to 4 and 255 s, long consumer hold-off, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
